/* rtl/ebd_pkg.sv */
// ----------------------------------------------------------------------------
// ebd_pkg
// shared widths, reset values, register codes and types of the beat detector
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int MEAN_W     = 16;
    localparam int SENS_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int DECAY_W    = 16;
    localparam int FLASH_W    = 17;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int OUT_FIFO_DEPTH    = 8;

    localparam logic [FLASH_W-1:0] FLASH_ONE   = 17'h10000;
    localparam logic [FLASH_W-1:0] FLASH_FLOOR = 17'd66;

    localparam logic [SENS_W-1:0]  SENS_RST    = 8'd48;
    localparam logic [HOLD_W-1:0]  HOLD_RST    = 16'd2400;
    localparam logic [MEAN_W-1:0]  MIN_AVG_RST = 16'd33;
    localparam logic [DECAY_W-1:0] DECAY_RST   = 16'd65405;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSITIVITY  = 2'd0,
        REG_HOLD_SAMPLES = 2'd1,
        REG_MIN_AVERAGE  = 2'd2,
        REG_FLASH_DECAY  = 2'd3
    } ebd_reg_t;

    typedef struct packed {
        logic [SENS_W-1:0]  sens;
        logic [HOLD_W-1:0]  hold;
        logic [MEAN_W-1:0]  min_avg;
        logic [DECAY_W-1:0] decay;
    } ebd_cfg_t;

    typedef struct packed {
        logic               beat_now;
        logic [COUNT_W-1:0] beat_total;
        logic [FLASH_W-1:0] flash_level;
        logic [MEAN_W-1:0]  mean_energy;
    } ebd_result_t;

endpackage

/* rtl/energy_beat_detector_unit.sv */
// ----------------------------------------------------------------------------
// energy_beat_detector_unit
// energy beat detector: moving mean of sample magnitudes, beat test with
// hold-off, beat counter and decaying flash level
// ----------------------------------------------------------------------------
// channel   | valid          | stall          | payload
// ----------+----------------+----------------+-------------------------------
// sample    | sample_valid   | sample_stall   | sample_value
// result    | result_valid   | result_stall   | beat_now, beat_total,
//           |                |                | flash_level, mean_energy
// config    | cfg_write      | none           | cfg_index, cfg_data
//
// one sample word per clock unless stalled; result via s0, s1, s2 regs and fifo
// stages: input reg, history ram and running sum, mean, beat test into fifo
// sample_stall rises when 8 words are in flight or queued in the result fifo
// history clears at reset through a wrap flag, no clearing pass
// result_stall backs the 8-entry fifo up into sample_stall, pipeline never stops
// ----------------------------------------------------------------------------
module energy_beat_detector_unit #(
    parameter int HISTORY_DEPTH = ebd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [ebd_pkg::SAMPLE_W-1:0]  sample_value,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 beat_now,
    output logic [ebd_pkg::COUNT_W-1:0]          beat_total,
    output logic [ebd_pkg::FLASH_W-1:0]          flash_level,
    output logic [ebd_pkg::MEAN_W-1:0]           mean_energy
);

    import ebd_pkg::*;

    localparam int LOG_D    = $clog2(HISTORY_DEPTH);
    localparam int SLOT_W   = LOG_D;
    localparam int SUM_W    = $clog2(HISTORY_DEPTH * (2 ** (MAG_W - 1)) + 1);
    localparam int PTR_W    = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W    = $clog2(OUT_FIFO_DEPTH + 1);
    localparam bit IS_POW2  = ((1 << LOG_D) == HISTORY_DEPTH);

    ebd_cfg_t            cfg_reg;

    logic                accept;
    logic [SAMPLE_W-1:0] sample_bits;
    logic [MAG_W-1:0]    in_mag;

    logic                s0_valid_reg;
    logic [MAG_W-1:0]    s0_mag_reg;
    logic                s1_valid_reg;
    logic [MAG_W-1:0]    s1_mag_reg;
    logic                s2_valid_reg;
    logic [MAG_W-1:0]    s2_mag_reg;
    logic [MEAN_W-1:0]   s2_mean_reg;

    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wrapped_reg;
    logic [MAG_W-1:0]    rd_data;
    logic [MAG_W-1:0]    old_mag;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [MEAN_W-1:0]   mean_calc;

    ebd_result_t         dec_result;
    ebd_result_t         fifo_mem [OUT_FIFO_DEPTH];
    ebd_result_t         head;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    fifo_count_reg;
    logic [CNT_W-1:0]    pending_reg;
    logic                push;
    logic                pop;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sens    <= SENS_RST;
            cfg_reg.hold    <= HOLD_RST;
            cfg_reg.min_avg <= MIN_AVG_RST;
            cfg_reg.decay   <= DECAY_RST;
        end
        else if (cfg_write)
        begin
            unique case (ebd_reg_t'(cfg_index))
                REG_SENSITIVITY:  cfg_reg.sens    <= cfg_data[SENS_W-1:0];
                REG_HOLD_SAMPLES: cfg_reg.hold    <= cfg_data[HOLD_W-1:0];
                REG_MIN_AVERAGE:  cfg_reg.min_avg <= cfg_data[MEAN_W-1:0];
                REG_FLASH_DECAY:  cfg_reg.decay   <= cfg_data[DECAY_W-1:0];
            endcase
        end
    end

    // input stage: magnitude of the sample word
    assign accept       = sample_valid && !sample_stall;
    assign sample_bits  = sample_value;
    assign in_mag       = sample_bits[SAMPLE_W-1] ? MAG_W'(~sample_bits + 1'b1)
                                                  : MAG_W'(sample_bits);
    assign sample_stall = (pending_reg == CNT_W'(OUT_FIFO_DEPTH));

    // history ring: read data always holds the entry at slot_reg
    assign slot_inc = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign rd_addr  = s0_valid_reg ? slot_inc : slot_reg;
    assign old_mag  = wrapped_reg ? rd_data : '0;
    assign sum_next = sum_reg - SUM_W'(old_mag) + SUM_W'(s0_mag_reg);

    ebd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s0_valid_reg),
        .wr_addr (slot_reg),
        .wr_data (s0_mag_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // mean of the window
    generate
        if (IS_POW2)
        begin : g_mean_shift
            assign mean_calc = sum_reg[LOG_D +: MEAN_W];
        end
        else
        begin : g_mean_recip
            localparam int RECIP_SHIFT = SUM_W + LOG_D;
            localparam int RECIP_W     = SUM_W + 1;
            localparam int PROD_W      = SUM_W + RECIP_W;
            localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
                ((64'd1 << RECIP_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
            logic [PROD_W-1:0] mean_prod;
            assign mean_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
            assign mean_calc = mean_prod[RECIP_SHIFT +: MEAN_W];
        end
    endgenerate

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            slot_reg     <= '0;
            wrapped_reg  <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            if (s0_valid_reg)
            begin
                slot_reg <= slot_inc;
                sum_reg  <= sum_next;
                if (slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s0_mag_reg  <= in_mag;
        s1_mag_reg  <= s0_mag_reg;
        s2_mag_reg  <= s1_mag_reg;
        s2_mean_reg <= mean_calc;
    end

    ebd_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s2_valid_reg),
        .item_mag   (s2_mag_reg),
        .item_mean  (s2_mean_reg),
        .cfg        (cfg_reg),
        .result     (dec_result)
    );

    // result fifo
    assign push = s2_valid_reg;
    assign pop  = result_valid && !result_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= dec_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   fifo_count_reg <= fifo_count_reg + 1'b1;
                2'b01:   fifo_count_reg <= fifo_count_reg - 1'b1;
                default: fifo_count_reg <= fifo_count_reg;
            endcase
            unique case ({accept, pop})
                2'b10:   pending_reg <= pending_reg + 1'b1;
                2'b01:   pending_reg <= pending_reg - 1'b1;
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign result_valid = (fifo_count_reg != '0);
    assign beat_now     = head.beat_now;
    assign beat_total   = head.beat_total;
    assign flash_level  = head.flash_level;
    assign mean_energy  = head.mean_energy;

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg >= fifo_count_reg)
        else $error("fewer words in flight than queued");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (fifo_count_reg == CNT_W'(OUT_FIFO_DEPTH))))
        else $error("result fifo overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("history wrap flag cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(HISTORY_DEPTH * (2 ** (MAG_W - 1))))
        else $error("running sum exceeds full window");

endmodule

/* rtl/ebd_ram.sv */
// ----------------------------------------------------------------------------
// ebd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ebd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/ebd_decide.sv */
// ----------------------------------------------------------------------------
// ebd_decide
// beat test, hold-off counter, beat counter and flash decay for one word
// ----------------------------------------------------------------------------
module ebd_decide (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [ebd_pkg::MAG_W-1:0]   item_mag,
    input  logic [ebd_pkg::MEAN_W-1:0]  item_mean,
    input  ebd_pkg::ebd_cfg_t           cfg,
    output ebd_pkg::ebd_result_t        result
);

    import ebd_pkg::*;

    localparam int SENS_FRAC    = 5;
    localparam int THRESH_W     = MEAN_W + SENS_W;
    localparam int FLASH_PROD_W = FLASH_W + DECAY_W;

    logic [HOLD_W-1:0]       holdoff_reg;
    logic [HOLD_W-1:0]       holdoff_next;
    logic [HOLD_W-1:0]       holdoff_load;
    logic [FLASH_W-1:0]      flash_reg;
    logic [FLASH_W-1:0]      flash_next;
    logic [FLASH_W-1:0]      flash_decayed;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [THRESH_W-1:0]     energy;
    logic [THRESH_W-1:0]     thresh;
    logic [FLASH_PROD_W-1:0] flash_prod;
    logic                    fire;

    always_comb
    begin
        energy = THRESH_W'(item_mag) << SENS_FRAC;
        thresh = THRESH_W'(item_mean) * THRESH_W'(cfg.sens);
        fire   = (holdoff_reg == '0) && (energy > thresh) && (item_mean > cfg.min_avg);

        holdoff_load = fire ? cfg.hold : holdoff_reg;
        holdoff_next = (holdoff_load != '0) ? holdoff_load - 1'b1 : holdoff_load;

        // one times decay is decay itself
        flash_prod    = FLASH_PROD_W'(flash_reg) * FLASH_PROD_W'(cfg.decay);
        flash_decayed = fire ? FLASH_W'(cfg.decay) : flash_prod[DECAY_W +: FLASH_W];
        flash_next    = (flash_decayed < FLASH_FLOOR) ? '0 : flash_decayed;

        count_next = fire ? count_reg + 1'b1 : count_reg;

        result.beat_now    = fire;
        result.beat_total  = count_next;
        result.flash_level = flash_next;
        result.mean_energy = item_mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= '0;
            flash_reg   <= '0;
            count_reg   <= '0;
        end
        else if (item_valid)
        begin
            holdoff_reg <= holdoff_next;
            flash_reg   <= flash_next;
            count_reg   <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        flash_reg < FLASH_ONE)
        else $error("flash level reached one after decay");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !fire) |=> (flash_reg <= $past(flash_reg)))
        else $error("flash level grew without a beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && (holdoff_reg != '0)) |=> (count_reg == $past(count_reg)))
        else $error("beat counted during hold-off");

endmodule

/* tb/tb_energy_beat_detector_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_energy_beat_detector_unit
// self-checking bench for the energy beat detector. A queue-fed driver offers
// audio sample words and predicts each result from its own copy of the
// magnitude history, hold-off, flash and beat count. A monitor compares every
// result word with the oldest prediction. Directed corner words come first,
// then register settings with random quiet/loud sample streams, random idling
// on both sides and one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_energy_beat_detector_unit;

    import ebd_pkg::*;

    localparam int HIST_LOG2 = $clog2(HISTORY_DEPTH_DEF);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_write = 1'b0;
    ebd_reg_t                   cfg_index = REG_SENSITIVITY;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic                       beat_now;
    logic [COUNT_W-1:0]         beat_total;
    logic [FLASH_W-1:0]         flash_level;
    logic [MEAN_W-1:0]          mean_energy;

    // predicted detector state and register copies
    logic [MAG_W-1:0]             mag_hist [HISTORY_DEPTH_DEF] = '{default: '0};
    logic [MAG_W+HIST_LOG2-1:0]   mag_total = '0;
    logic [HIST_LOG2-1:0]         hist_pos = '0;
    logic [HOLD_W-1:0]            holdoff_cnt = '0;
    logic [FLASH_W-1:0]           flash_lvl = '0;
    logic [COUNT_W-1:0]           beat_cnt = '0;
    logic [SENS_W-1:0]            sens_q = SENS_RST;
    logic [HOLD_W-1:0]            hold_q = HOLD_RST;
    logic [MEAN_W-1:0]            min_avg_q = MIN_AVG_RST;
    logic [DECAY_W-1:0]           decay_q = DECAY_RST;

    logic signed [SAMPLE_W-1:0] sample_queue [$];
    ebd_result_t                beat_reports [$];
    int                         n_queued = 0;
    int                         n_accepted = 0;
    int                         n_mismatch = 0;
    int unsigned                sender_idle_pct = 34;
    int unsigned                receiver_idle_pct = 80;
    int                         hold_requests = 0;
    int                         hold_served = 0;
    int                         hold_left = 0;

    energy_beat_detector_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .beat_now     (beat_now),
        .beat_total   (beat_total),
        .flash_level  (flash_level),
        .mean_energy  (mean_energy)
    );

    always #5 clk = ~clk;

    function automatic ebd_result_t detect_beat(input logic signed [SAMPLE_W-1:0] s);
        ebd_result_t      r;
        logic [MAG_W-1:0] mag;
        logic [MEAN_W-1:0] mean;
        logic [63:0]      prod;
        mag = s[SAMPLE_W-1] ? MAG_W'(-s) : MAG_W'(s);
        mag_total = mag_total - mag_hist[hist_pos] + mag;
        mag_hist[hist_pos] = mag;
        hist_pos = hist_pos + 1'b1;
        mean = MEAN_W'(mag_total >> HIST_LOG2);
        r.beat_now = 1'b0;
        if (holdoff_cnt == '0 && (32'(mag) << 5) > 32'(mean) * 32'(sens_q) &&
            mean > min_avg_q)
        begin
            r.beat_now = 1'b1;
            flash_lvl = FLASH_ONE;
            holdoff_cnt = hold_q;
            beat_cnt = beat_cnt + 1'b1;
        end
        if (holdoff_cnt != '0)
            holdoff_cnt = holdoff_cnt - 1'b1;
        prod = 64'(flash_lvl) * 64'(decay_q);
        flash_lvl = prod[FLASH_W+15:16];
        if (flash_lvl < FLASH_FLOOR)
            flash_lvl = '0;
        r.beat_total = beat_cnt;
        r.flash_level = flash_lvl;
        r.mean_energy = mean;
        return r;
    endfunction

    // mostly quiet noise with loud spikes, some fully random words
    function automatic logic signed [SAMPLE_W-1:0] audio_sample();
        int pick;
        int amp;
        pick = $urandom_range(0, 99);
        amp = $urandom_range(0, 4000);
        if (pick < 15)
            return SAMPLE_W'($urandom);
        if (pick < 30)
            return $urandom_range(0, 1) ? SAMPLE_W'(-int'($urandom_range(20000, 32768)))
                                        : SAMPLE_W'($urandom_range(20000, 32767));
        return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    task automatic flag_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic put_reg(input ebd_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SENSITIVITY:  sens_q = val[SENS_W-1:0];
            REG_HOLD_SAMPLES: hold_q = val;
            REG_MIN_AVERAGE:  min_avg_q = val;
            REG_FLASH_DECAY:  decay_q = val;
        endcase
    endtask

    task automatic program_detector(input logic [CFG_DATA_W-1:0] sens,
                                    input logic [CFG_DATA_W-1:0] hold,
                                    input logic [CFG_DATA_W-1:0] min_avg,
                                    input logic [CFG_DATA_W-1:0] decay);
        put_reg(REG_SENSITIVITY, sens);
        put_reg(REG_HOLD_SAMPLES, hold);
        put_reg(REG_MIN_AVERAGE, min_avg);
        put_reg(REG_FLASH_DECAY, decay);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic offer(input logic signed [SAMPLE_W-1:0] s);
        sample_queue.push_back(s);
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || beat_reports.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_phase(input int n, input int s_idle, input int r_idle);
        @(negedge clk);
        sender_idle_pct = s_idle;
        receiver_idle_pct = r_idle;
        repeat (n) offer(audio_sample());
        drain();
    endtask

    // sample word driver and prediction on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                beat_reports.push_back(detect_beat(sample_value));
                n_accepted++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample_value <= sample_queue.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= 300;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result word monitor
    always @(posedge clk)
    begin : result_check
        ebd_result_t due;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (beat_reports.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word beat=%0b total=%0d flash=%0d mean=%0d",
                                            beat_now, beat_total, flash_level, mean_energy));
                end
                else
                begin
                    due = beat_reports.pop_front();
                    if (beat_now !== due.beat_now || beat_total !== due.beat_total ||
                        flash_level !== due.flash_level || mean_energy !== due.mean_energy)
                    begin
                        flag_mismatch($sformatf(
                            "expected beat=%0b total=%0d flash=%0d mean=%0d, got beat=%0b total=%0d flash=%0d mean=%0d",
                            due.beat_now, due.beat_total, due.flash_level, due.mean_energy,
                            beat_now, beat_total, flash_level, mean_energy));
                    end
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int corner_words [10] = '{32767, -32768, -32768, 0, 1, -1, 16384, -2, 32767, -32767};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero hold, no floor, masked sensitivity bits, decay to nothing
        program_detector(16'hAB10, 16'd0, 16'd0, 16'd0);
        @(negedge clk);
        foreach (corner_words[i])
            offer(SAMPLE_W'(corner_words[i]));
        drain();

        // hold-off length with full-scale alternating words
        program_detector(16'd0, 16'd3, 16'd100, 16'd65535);
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            offer(SAMPLE_W'(i[0] ? 32767 : -32768));
        drain();

        program_detector(16'd48, 16'd2400, 16'd33, 16'd65405);
        random_phase(250, 34, 80);
        program_detector(16'd160, 16'd5, 16'd0, 16'd60000);
        random_phase(300, 34, 80);
        program_detector(16'd16, 16'd0, 16'd500, 16'd1000);
        random_phase(300, 80, 34);
        program_detector(16'd96, 16'd20, 16'd32768, 16'd65535);
        random_phase(150, 80, 34);
        program_detector(16'($urandom_range(16, 160)), 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 3000)), 16'($urandom_range(50000, 65535)));
        @(negedge clk);
        hold_requests++;
        random_phase(350, 0, 0);
        program_detector(16'd255, 16'd65535, 16'd0, 16'd65535);
        random_phase(300, 0, 0);

        repeat (8) @(posedge clk);
        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/ebd_pkg.sv
rtl/ebd_ram.sv
rtl/ebd_decide.sv
rtl/energy_beat_detector_unit.sv
tb/tb_energy_beat_detector_unit.sv
